@@ rtl/core/itrd_pkg.sv @@
// Shared types, codes and helpers for the integer-to-radix-digits block.
`timescale 1ns / 1ps

package itrd_pkg;

    // Radix selector codes; the unused code is handled as hexadecimal.
    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned NARROW_W = 32;
    localparam int unsigned BCD_W    = 80;   // 20 decimal digits
    localparam int unsigned WORK_W   = 88;   // 22 digit slots of up to 4 bits

    localparam logic [6:0] CH_ZERO    = 7'd48;
    localparam logic [6:0] CH_UPPER_A = 7'd65;
    localparam logic [6:0] CH_LOWER_A = 7'd97;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;        // capture a new input item
        logic dabble;      // one binary-to-BCD shift step
        logic dabble_last; // final step: move BCD result to the digit register
        logic shift;       // drop the top digit
        logic emit;        // register the top digit as a result
        logic last;        // the emitted digit is the least significant one
    } t_dp_cmd;

    typedef struct packed {
        logic top_zero;    // the top digit of the digit register is zero
    } t_dp_sts;

    // Digit positions for a radix and width.
    function automatic logic [4:0] digit_count(input logic [1:0] sel, input logic wide);
        logic [4:0] n;
        unique case (sel)
            RADIX_OCT: n = wide ? 5'd22 : 5'd11;
            RADIX_DEC: n = wide ? 5'd20 : 5'd10;
            default:   n = wide ? 5'd16 : 5'd8;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/core/itrd_ctrl.sv @@
// Sequencer for the integer-to-radix-digits block: conversion steps and digit emission.
`timescale 1ns / 1ps

module itrd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_wide,
    input  logic [1:0]       i_radix_sel,
    input  itrd_pkg::t_dp_sts i_sts,
    output itrd_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);
    import itrd_pkg::*;

    t_state     r_state, n_state;
    logic [6:0] r_cnt;   // BCD shift steps left
    logic [4:0] r_left;  // digit positions left

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_left <= digit_count(i_radix_sel, i_wide);
                        r_cnt  <= i_wide ? 7'd64 : 7'd32;
                    end
                end
                ST_CONV: r_cnt <= r_cnt - 7'd1;
                ST_SKIP: begin
                    if (i_sts.top_zero && r_left > 5'd1) begin
                        r_left <= r_left - 5'd1;
                    end
                end
                ST_EMIT: r_left <= r_left - 5'd1;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_radix_sel == RADIX_DEC) ? ST_CONV : ST_SKIP;
                end
            end
            ST_CONV: begin
                if (r_cnt == 7'd1) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (!(i_sts.top_zero && r_left > 5'd1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_left == 5'd1) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_CONV: begin
                o_cmd.dabble      = 1'b1;
                o_cmd.dabble_last = (r_cnt == 7'd1);
            end
            ST_SKIP: begin
                o_cmd.shift = i_sts.top_zero && r_left > 5'd1;
            end
            ST_EMIT: begin
                o_cmd.shift = 1'b1;
                o_cmd.emit  = 1'b1;
                o_cmd.last  = (r_left == 5'd1);
            end
            default: ;
        endcase
    end

    a_emit_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> r_left != 5'd0)
        else $error("emitting with no digit positions left");

    a_conv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CONV |-> r_cnt != 7'd0)
        else $error("BCD step counter ran out during conversion");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_left == 5'd1) |=> r_state == ST_IDLE)
        else $error("sequencer did not return to idle after last digit");

    a_skip_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == ST_EMIT && !o_cmd.load && !o_cmd.dabble))
        else $error("emit issued outside the emit phase");

endmodule

@@ rtl/core/itrd_dp.sv @@
// Datapath: binary-to-BCD shifter, digit register and character formatting.
`timescale 1ns / 1ps

module itrd_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itrd_pkg::t_dp_cmd i_cmd,
    input  logic [63:0]       i_value,
    input  logic              i_wide,
    input  logic [1:0]        i_radix_sel,
    input  logic              i_upper_case,
    output itrd_pkg::t_dp_sts o_sts,
    output logic              o_strobe,
    output logic [6:0]        o_digit_char,
    output logic              o_is_last
);
    import itrd_pkg::*;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd, adj_bcd;
    logic [WORK_W-1:0]  r_work;
    logic               r_wide, r_oct, r_upper;
    logic               r_strobe;
    logic [6:0]         r_char;
    logic               r_last;
    logic [3:0]         top;
    logic [6:0]         ch;

    // add-3 correction on every BCD digit, then shift in the next binary bit
    always_comb begin
        for (int k = 0; k < BCD_W / 4; k++) begin
            adj_bcd[k*4 +: 4] = (r_bcd[k*4 +: 4] >= 4'd5) ? r_bcd[k*4 +: 4] + 4'd3
                                                           : r_bcd[k*4 +: 4];
        end
        n_bcd = {adj_bcd[BCD_W-2:0], r_bin[VALUE_W-1]};
    end

    assign top = r_oct ? {1'b0, r_work[WORK_W-1 -: 3]} : r_work[WORK_W-1 -: 4];
    assign o_sts.top_zero = (top == 4'd0);

    always_comb begin
        if (top < 4'd10) begin
            ch = CH_ZERO + {3'b000, top};
        end else begin
            ch = (r_upper ? CH_UPPER_A : CH_LOWER_A) + {3'b000, top} - 7'd10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wide  <= i_wide;
            r_oct   <= (i_radix_sel == RADIX_OCT);
            r_upper <= i_upper_case;
            r_bcd   <= '0;
            r_bin   <= i_wide ? i_value : {i_value[NARROW_W-1:0], {NARROW_W{1'b0}}};
            case (i_radix_sel)
                RADIX_OCT: r_work <= i_wide ? {2'b00, i_value, 22'd0}
                                            : {1'b0, i_value[NARROW_W-1:0], 55'd0};
                default:   r_work <= i_wide ? {i_value, 24'd0}
                                            : {i_value[NARROW_W-1:0], 56'd0};
            endcase
        end else if (i_cmd.dabble) begin
            r_bcd <= n_bcd;
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            if (i_cmd.dabble_last) begin
                r_work <= r_wide ? {n_bcd, 8'd0} : {n_bcd[39:0], 48'd0};
            end
        end else if (i_cmd.shift) begin
            r_work <= r_oct ? {r_work[WORK_W-4:0], 3'b000} : {r_work[WORK_W-5:0], 4'b0000};
        end
        if (i_cmd.emit) begin
            r_char <= ch;
            r_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_digit_char = r_char;
    assign o_is_last    = r_last;

endmodule

@@ rtl/core/integer_to_radix_digits_top.sv @@
// Top level of the integer-to-radix-digits converter.
`timescale 1ns / 1ps
//
// Converts an unsigned 32- or 64-bit integer to ASCII digits in octal, decimal
// or hexadecimal, most significant digit first, leading zeros suppressed.
// Input: drive i_value, i_wide, i_radix_sel, i_upper_case and pulse start;
// the transfer happens at a rising edge with start high and busy low.
// Output: one character per o_valid pulse on o_digit_char; o_is_last marks
// the least significant digit. The receiver cannot stall; every strobe is a
// transfer. A zero value gives a single '0'.
// Sequence: octal/hex shift digits straight out of the digit register. Decimal
// first runs a binary-to-BCD shift-and-add-3 pass, one bit per cycle over the
// 32 or 64 input bits. Then the skip phase drops leading zeros from the top of
// the digit register, and the emit phase registers each remaining digit as a
// character. Busy holds from the accept until the last digit is registered.
// The number of digit positions runs from 8 to 22.
// Reset (synchronous, active low) returns the sequencer to idle and clears
// the output strobe; no item survives it.
//
module integer_to_radix_digits_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_value,
    input  logic        i_wide,
    input  logic [1:0]  i_radix_sel,
    input  logic        i_upper_case,
    output logic        o_valid,
    output logic [6:0]  o_digit_char,
    output logic        o_is_last
);
    import itrd_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    ctrl_busy;

    // sequencer: BCD step count, digit positions, skip/emit phases
    itrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_wide      (i_wide),
        .i_radix_sel (i_radix_sel),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (ctrl_busy)
    );

    // datapath: BCD shifter, digit register, ASCII output register
    itrd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .i_wide       (i_wide),
        .i_radix_sel  (i_radix_sel),
        .i_upper_case (i_upper_case),
        .o_sts        (sts),
        .o_strobe     (o_valid),
        .o_digit_char (o_digit_char),
        .o_is_last    (o_is_last)
    );

    assign busy = ctrl_busy;

endmodule
